[hw/rtl/smslp_pkg.sv]
// shared types, constants and helpers of the sms list response parser
package smslp_pkg;

  // parser phase
  typedef enum logic [3:0] {
    PH_SEARCH         = 4'd0,
    PH_SKIP_TAG       = 4'd1,
    PH_SLOT           = 4'd2,
    PH_SKIP_QUOTE     = 4'd3,
    PH_STATUS         = 4'd4,
    PH_SKIP_TO_NUMBER = 4'd5,
    PH_NUMBER         = 4'd6,
    PH_SKIP_TO_NAME   = 4'd7,
    PH_NAME           = 4'd8,
    PH_SKIP_TO_DATE   = 4'd9,
    PH_DATE           = 4'd10,
    PH_SKIP_TO_MSG    = 4'd11,
    PH_MESSAGE        = 4'd12
  } phase_e;

  // result item kinds
  localparam logic [2:0] KIND_HEADER   = 3'd0;
  localparam logic [2:0] KIND_NUMBER   = 3'd1;
  localparam logic [2:0] KIND_DATETIME = 3'd2;
  localparam logic [2:0] KIND_MESSAGE  = 3'd3;
  localparam logic [2:0] KIND_REC_END  = 3'd4;

  // status codes
  localparam logic [2:0] STAT_REC_UNREAD = 3'd0;
  localparam logic [2:0] STAT_REC_READ   = 3'd1;
  localparam logic [2:0] STAT_STO_UNSENT = 3'd2;
  localparam logic [2:0] STAT_STO_SENT   = 3'd3;
  localparam logic [2:0] STAT_ALL        = 3'd4;
  localparam logic [2:0] STAT_UNKNOWN    = 3'd5;

  // characters
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_U     = 8'h55;

  localparam logic [2:0]  TAG_LEN  = 3'd5;
  localparam logic [16:0] SLOT_MAX = 17'd65535;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  item_kind;
    logic [7:0]  char_value;
    logic [15:0] slot_number;
    logic [2:0]  status_code;
    logic [3:0]  record_index;
    logic        record_complete;
  } out_item_t;

  // expected character of the "+CMGL" tag at a match position
  function automatic logic [7:0] tag_char(input logic [2:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    unique case (pos)
      3'd0:    ch = CH_PLUS;
      3'd1:    ch = CH_C;
      3'd2:    ch = CH_M;
      3'd3:    ch = CH_G;
      3'd4:    ch = CH_L;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // status class from first and fifth letter of the status word
  function automatic logic [2:0] classify(input logic [7:0] first, input logic [7:0] fifth);
    logic [2:0] code;
    code = STAT_UNKNOWN;
    if (first == CH_R) begin
      if (fifth == CH_U) code = STAT_REC_UNREAD;
      else if (fifth == CH_R) code = STAT_REC_READ;
    end else if (first == CH_S) begin
      if (fifth == CH_U) code = STAT_STO_UNSENT;
      else if (fifth == CH_S) code = STAT_STO_SENT;
    end else if (first == CH_A) begin
      code = STAT_ALL;
    end
    return code;
  endfunction

endpackage

[hw/rtl/smslp_stream_if.sv]
// valid/ready stream interface with a typed payload
interface smslp_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[hw/rtl/smslp_in_stage.sv]
// input register stage holding one received byte
module smslp_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  smslp_stream_if.sink        in_i,
  input  logic                advance_i,
  output logic                valid_o,
  output smslp_pkg::in_item_t item_o
);
  import smslp_pkg::*;

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     take;

  assign in_i.ready = !valid_q || advance_i;
  assign take       = in_i.valid && in_i.ready;
  assign valid_d    = take ? 1'b1 : (valid_q && !advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= in_i.payload;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
endmodule

[hw/rtl/smslp_parser.sv]
// record parser: phase state and per-byte decode
module smslp_parser #(
  parameter int MAX_RECORDS      = 16,
  parameter int NUMBER_MAX_LEN   = 32,
  parameter int DATETIME_MAX_LEN = 32,
  parameter int MESSAGE_MAX_LEN  = 160
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  smslp_pkg::in_item_t  item_i,
  output logic                 res_valid_o,
  output smslp_pkg::out_item_t res_o
);
  import smslp_pkg::*;

  localparam int RecW = $clog2(MAX_RECORDS + 1);

  phase_e          phase_q, phase_d;
  logic [2:0]      tag_cnt_q, tag_cnt_d;
  logic [1:0]      skip_q, skip_d;
  logic [15:0]     slot_q, slot_d;
  logic [7:0]      first_q, first_d;
  logic [7:0]      fifth_q, fifth_d;
  logic [2:0]      pos_q, pos_d;
  logic [7:0]      flen_q, flen_d;
  logic [RecW-1:0] rec_q, rec_d;

  logic [7:0]  b;
  logic [7:0]  rec_ext;
  logic [7:0]  rec_prev;
  logic [2:0]  tag_next;
  logic        skip_fin;
  logic [16:0] slot_prod;

  assign b        = item_i.text_byte;
  assign rec_ext  = 8'(rec_q);
  assign rec_prev = rec_ext - 8'd1;
  assign skip_fin = (skip_q <= 2'd1);
  assign slot_prod = 17'(20'(slot_q) * 20'd10 + 20'(4'(b - CH_ZERO)) > 20'(SLOT_MAX)
                         ? SLOT_MAX
                         : 17'(20'(slot_q) * 20'd10 + 20'(4'(b - CH_ZERO))));

  always_comb begin
    tag_next = 3'd0;
    if (b == tag_char(tag_cnt_q)) tag_next = tag_cnt_q + 3'd1;
    else if (b == CH_PLUS) tag_next = 3'd1;
  end

  always_comb begin
    phase_d   = phase_q;
    tag_cnt_d = tag_cnt_q;
    skip_d    = skip_q;
    slot_d    = slot_q;
    first_d   = first_q;
    fifth_d   = fifth_q;
    pos_d     = pos_q;
    flen_d    = flen_q;
    rec_d     = rec_q;

    res_valid_o           = 1'b0;
    res_o.item_kind       = KIND_HEADER;
    res_o.char_value      = 8'h00;
    res_o.record_index    = rec_prev[3:0];
    res_o.record_complete = 1'b0;

    // carriage returns never reach the phase logic
    if (fire_i && b != CH_CR) begin
      unique case (phase_q)
        PH_SEARCH: begin
          tag_cnt_d = tag_next;
          if (tag_next == TAG_LEN) begin
            tag_cnt_d = 3'd0;
            if (rec_ext < 8'(MAX_RECORDS)) begin
              phase_d = PH_SKIP_TAG;
              skip_d  = 2'd2;
            end
          end
        end
        PH_SKIP_TAG: begin
          skip_d = skip_fin ? 2'd0 : skip_q - 2'd1;
          if (skip_fin) begin
            phase_d = PH_SLOT;
            slot_d  = 16'd0;
          end
        end
        PH_SLOT: begin
          if (b >= CH_ZERO && b <= CH_NINE) begin
            slot_d = slot_prod[15:0];
          end else begin
            phase_d = PH_SKIP_QUOTE;
            skip_d  = 2'd1;
          end
        end
        PH_SKIP_QUOTE: begin
          skip_d = skip_fin ? 2'd0 : skip_q - 2'd1;
          if (skip_fin) begin
            phase_d = PH_STATUS;
            first_d = 8'h00;
            fifth_d = 8'h00;
            pos_d   = 3'd0;
          end
        end
        PH_STATUS: begin
          if (b == CH_QUOTE) begin
            res_valid_o        = 1'b1;
            res_o.item_kind    = KIND_HEADER;
            res_o.record_index = rec_ext[3:0];
            rec_d   = rec_q + RecW'(1);
            phase_d = PH_SKIP_TO_NUMBER;
            skip_d  = 2'd2;
          end else begin
            if (pos_q == 3'd0) first_d = b;
            if (pos_q == 3'd4) fifth_d = b;
            if (pos_q < 3'd5) pos_d = pos_q + 3'd1;
          end
        end
        PH_SKIP_TO_NUMBER: begin
          skip_d = skip_fin ? 2'd0 : skip_q - 2'd1;
          if (skip_fin) begin
            phase_d = PH_NUMBER;
            flen_d  = 8'd0;
          end
        end
        PH_NUMBER: begin
          if (b == CH_QUOTE) begin
            phase_d = PH_SKIP_TO_NAME;
            skip_d  = 2'd2;
          end else if (flen_q < 8'(NUMBER_MAX_LEN)) begin
            flen_d           = flen_q + 8'd1;
            res_valid_o      = 1'b1;
            res_o.item_kind  = KIND_NUMBER;
            res_o.char_value = b;
          end
        end
        PH_SKIP_TO_NAME: begin
          skip_d = skip_fin ? 2'd0 : skip_q - 2'd1;
          if (skip_fin) phase_d = PH_NAME;
        end
        PH_NAME: begin
          if (b == CH_QUOTE) begin
            phase_d = PH_SKIP_TO_DATE;
            skip_d  = 2'd2;
          end
        end
        PH_SKIP_TO_DATE: begin
          skip_d = skip_fin ? 2'd0 : skip_q - 2'd1;
          if (skip_fin) begin
            phase_d = PH_DATE;
            flen_d  = 8'd0;
          end
        end
        PH_DATE: begin
          if (b == CH_QUOTE) begin
            phase_d = PH_SKIP_TO_MSG;
            skip_d  = 2'd1;
          end else if (flen_q < 8'(DATETIME_MAX_LEN)) begin
            flen_d           = flen_q + 8'd1;
            res_valid_o      = 1'b1;
            res_o.item_kind  = KIND_DATETIME;
            res_o.char_value = b;
          end
        end
        PH_SKIP_TO_MSG: begin
          skip_d = skip_fin ? 2'd0 : skip_q - 2'd1;
          if (skip_fin) begin
            phase_d = PH_MESSAGE;
            flen_d  = 8'd0;
          end
        end
        PH_MESSAGE: begin
          if (b == CH_LF) begin
            res_valid_o           = 1'b1;
            res_o.item_kind       = KIND_REC_END;
            res_o.record_complete = 1'b1;
            phase_d   = PH_SEARCH;
            tag_cnt_d = 3'd0;
          end else if (flen_q < 8'(MESSAGE_MAX_LEN)) begin
            flen_d           = flen_q + 8'd1;
            res_valid_o      = 1'b1;
            res_o.item_kind  = KIND_MESSAGE;
            res_o.char_value = b;
          end
        end
        default: begin
          phase_d   = PH_SEARCH;
          tag_cnt_d = 3'd0;
        end
      endcase
    end

    // slot and status reflect the record as it stands after this byte
    res_o.slot_number = slot_d;
    res_o.status_code = classify(first_d, fifth_d);

    if (fire_i && item_i.last_byte) begin
      // an open record whose header went out is closed as cut off
      if (phase_d >= PH_SKIP_TO_NUMBER && phase_d <= PH_MESSAGE) begin
        res_valid_o           = 1'b1;
        res_o.item_kind       = KIND_REC_END;
        res_o.char_value      = 8'h00;
        res_o.record_index    = 4'(rec_d - RecW'(1));
        res_o.record_complete = 1'b0;
      end
      phase_d   = PH_SEARCH;
      tag_cnt_d = 3'd0;
      skip_d    = 2'd0;
      slot_d    = 16'd0;
      first_d   = 8'h00;
      fifth_d   = 8'h00;
      pos_d     = 3'd0;
      flen_d    = 8'd0;
      rec_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_SEARCH;
      tag_cnt_q <= 3'd0;
      skip_q    <= 2'd0;
      slot_q    <= 16'd0;
      first_q   <= 8'h00;
      fifth_q   <= 8'h00;
      pos_q     <= 3'd0;
      flen_q    <= 8'd0;
      rec_q     <= '0;
    end else begin
      phase_q   <= phase_d;
      tag_cnt_q <= tag_cnt_d;
      skip_q    <= skip_d;
      slot_q    <= slot_d;
      first_q   <= first_d;
      fifth_q   <= fifth_d;
      pos_q     <= pos_d;
      flen_q    <= flen_d;
      rec_q     <= rec_d;
    end
  end

  a_rec_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    8'(rec_q) <= 8'(MAX_RECORDS))
    else $error("record count above limit");

  a_skip_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skip_q <= 2'd2)
    else $error("skip count out of range");

  a_open_has_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q >= PH_SKIP_TO_NUMBER && phase_q <= PH_MESSAGE) |-> rec_q != '0)
    else $error("record body without header");

  a_last_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && item_i.last_byte) |=> (phase_q == PH_SEARCH && rec_q == '0))
    else $error("parser not back to search after last byte");
endmodule

[hw/rtl/smslp_out_stage.sv]
// result register driving the output stream
module smslp_out_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  logic                 res_valid_i,
  input  smslp_pkg::out_item_t res_i,
  output logic                 space_o,
  smslp_stream_if.source       out_o
);
  import smslp_pkg::*;

  logic      valid_q, valid_d;
  out_item_t data_q;

  assign space_o = !valid_q || out_o.ready;
  assign valid_d = load_i ? res_valid_i : (valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && res_valid_i) begin
      data_q <= res_i;
    end
  end

  assign out_o.valid   = valid_q;
  assign out_o.payload = data_q;
endmodule

[hw/rtl/sms_list_response_parser_top.sv]
// top level of the sms list response parser
// Parses the text of a modem's SMS list response one byte per transfer.
// Carriage returns are dropped; each "+CMGL" record yields a header item
// (slot number, saturating at 65535, and status class), then the characters
// of the number, date/time and message fields, then a record-end item. The
// name field is skipped, characters past a field's length limit are dropped,
// and tags beyond MAX_RECORDS in one response are ignored. A byte flagged
// last_byte is processed and then returns the parser to its reset state; a
// record still open at that point is closed with record_complete = 0.
// Throughput is one byte per clock while no result waits with ready low.
// A byte is held in the input register and decoded by the single-pass
// phase logic into the result register; bytes producing no result are
// consumed without an output transfer. While a result waits with ready
// low nothing is decoded; the input register then takes at most one more
// byte before in_i.ready drops.
module sms_list_response_parser_top #(
  parameter int MAX_RECORDS      = 16,
  parameter int NUMBER_MAX_LEN   = 32,
  parameter int DATETIME_MAX_LEN = 32,
  parameter int MESSAGE_MAX_LEN  = 160
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  smslp_stream_if.sink   in_i,
  smslp_stream_if.source out_o
);
  import smslp_pkg::*;

  // registered input byte
  logic      stage_valid;
  in_item_t  stage_item;

  // decode result
  logic      res_valid;
  out_item_t res;

  // byte leaves the input register when the result register has room
  logic      space;
  logic      fire;

  assign fire = stage_valid && space;

  smslp_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .advance_i (fire),
    .valid_o   (stage_valid),
    .item_o    (stage_item)
  );

  smslp_parser #(
    .MAX_RECORDS      (MAX_RECORDS),
    .NUMBER_MAX_LEN   (NUMBER_MAX_LEN),
    .DATETIME_MAX_LEN (DATETIME_MAX_LEN),
    .MESSAGE_MAX_LEN  (MESSAGE_MAX_LEN)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .item_i      (stage_item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  smslp_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire),
    .res_valid_i (res_valid),
    .res_i       (res),
    .space_o     (space),
    .out_o       (out_o)
  );
endmodule

[bench/testbench.sv]
// self-checking testbench for the sms list response parser
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import smslp_pkg::*;

  // block configuration, kept at the default build
  localparam int MAX_RECORDS      = 16;
  localparam int NUMBER_MAX_LEN   = 32;
  localparam int DATETIME_MAX_LEN = 32;
  localparam int MESSAGE_MAX_LEN  = 160;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 12;
  // cycles in a row without any transfer before the run is declared hung;
  // the longest correct stretch is a sender gap plus a receiver stall plus
  // the pipeline, so this leaves a wide margin
  localparam int STALL_LIMIT  = 200;
  // settle time after the last expected result
  localparam int TAIL_CYCLES  = 10;
  localparam int RANDOM_BYTES = 100;

  // the record tag, first character in the top byte
  localparam logic [39:0] CMGL_TAG = {CH_PLUS, CH_C, CH_M, CH_G, CH_L};

  logic clk_i = 1'b0;
  logic rst_ni;

  smslp_stream_if #(.payload_t(in_item_t))  in_if ();
  smslp_stream_if #(.payload_t(out_item_t)) out_if ();

  sms_list_response_parser_top #(
    .MAX_RECORDS      (MAX_RECORDS),
    .NUMBER_MAX_LEN   (NUMBER_MAX_LEN),
    .DATETIME_MAX_LEN (DATETIME_MAX_LEN),
    .MESSAGE_MAX_LEN  (MESSAGE_MAX_LEN)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------------
  // parser prediction: own copy of the parse state
  // ---------------------------------------------------------------------
  phase_e      parse_ph;
  logic [2:0]  tag_pos;
  logic [1:0]  skip_left;
  logic [15:0] slot_acc;
  logic [7:0]  stat_first;
  logic [7:0]  stat_fifth;
  logic [2:0]  stat_pos;
  logic [7:0]  field_len;
  logic [4:0]  rec_count;

  // results predicted but not yet seen at the output, oldest first
  out_item_t predicted_items[$];

  int fail_count = 0;
  int byte_count = 0;

  // idle control, in percent per transfer
  int sender_gap_pct = 0;
  int sink_stall_pct = 0;
  // chance of a carriage return slipped in before a generated byte
  int cr_noise_pct   = 0;

  // text of the response being built
  logic [7:0] text_q[$];

  function automatic void clear_parser();
    parse_ph   = PH_SEARCH;
    tag_pos    = '0;
    skip_left  = '0;
    slot_acc   = '0;
    stat_first = '0;
    stat_fifth = '0;
    stat_pos   = '0;
    field_len  = '0;
    rec_count  = '0;
  endfunction

  function automatic logic [2:0] status_class(input logic [7:0] first,
                                               input logic [7:0] fifth);
    case (first)
      CH_R: if (fifth == CH_U) return STAT_REC_UNREAD;
            else if (fifth == CH_R) return STAT_REC_READ;
      CH_S: if (fifth == CH_U) return STAT_STO_UNSENT;
            else if (fifth == CH_S) return STAT_STO_SENT;
      CH_A: return STAT_ALL;
      default: ;
    endcase
    return STAT_UNKNOWN;
  endfunction

  // result item built from the current slot and status letters
  function automatic out_item_t make_item(input logic [2:0] kind, input logic [7:0] ch,
                                          input logic [3:0] idx, input logic done);
    out_item_t it;
    it.item_kind       = kind;
    it.char_value      = ch;
    it.slot_number     = slot_acc;
    it.status_code     = status_class(stat_first, stat_fifth);
    it.record_index    = idx;
    it.record_complete = done;
    return it;
  endfunction

  // counts a skipped byte, true on the last one of the skip
  function automatic bit skip_finished();
    if (skip_left <= 2'd1) begin
      skip_left = 2'd0;
      return 1'b1;
    end
    skip_left = skip_left - 2'd1;
    return 1'b0;
  endfunction

  // field character, dropped once the field is at its length limit
  function automatic bit take_field_char(input logic [2:0] kind, input logic [7:0] ch,
                                         input int limit, output out_item_t item);
    item = '0;
    if (field_len >= limit) return 1'b0;
    field_len = field_len + 8'd1;
    item = make_item(kind, ch, rec_count[3:0] - 4'd1, 1'b0);
    return 1'b1;
  endfunction

  // advances the parse state by one byte, returns whether a result follows
  function automatic bit parse_text_byte(input logic [7:0] b, input logic last,
                                         output out_item_t item);
    int unsigned acc;
    bit          emit;
    emit = 1'b0;
    item = '0;
    if (b != CH_CR) begin
      case (parse_ph)
        PH_SEARCH: begin
          if (tag_pos < TAG_LEN && b == CMGL_TAG[39 - 8 * tag_pos -: 8]) begin
            tag_pos = tag_pos + 3'd1;
          end else begin
            tag_pos = (b == CH_PLUS) ? 3'd1 : 3'd0;
          end
          if (tag_pos == TAG_LEN) begin
            tag_pos = 3'd0;
            // past the record limit the tag is ignored
            if (rec_count < MAX_RECORDS) begin
              parse_ph  = PH_SKIP_TAG;
              skip_left = 2'd2;
            end
          end
        end
        PH_SKIP_TAG: if (skip_finished()) begin
          parse_ph = PH_SLOT;
          slot_acc = '0;
        end
        PH_SLOT: begin
          if (b >= CH_ZERO && b <= CH_NINE) begin
            acc = slot_acc * 10 + (b - CH_ZERO);
            slot_acc = (acc > 65535) ? 16'hFFFF : acc[15:0];
          end else begin
            parse_ph  = PH_SKIP_QUOTE;
            skip_left = 2'd1;
          end
        end
        PH_SKIP_QUOTE: if (skip_finished()) begin
          parse_ph   = PH_STATUS;
          stat_first = '0;
          stat_fifth = '0;
          stat_pos   = '0;
        end
        PH_STATUS: begin
          if (b == CH_QUOTE) begin
            item      = make_item(KIND_HEADER, 8'h00, rec_count[3:0], 1'b0);
            emit      = 1'b1;
            rec_count = rec_count + 5'd1;
            parse_ph  = PH_SKIP_TO_NUMBER;
            skip_left = 2'd2;
          end else begin
            if (stat_pos == 3'd0) stat_first = b;
            if (stat_pos == 3'd4) stat_fifth = b;
            if (stat_pos < 3'd5) stat_pos = stat_pos + 3'd1;
          end
        end
        PH_SKIP_TO_NUMBER: if (skip_finished()) begin
          parse_ph  = PH_NUMBER;
          field_len = '0;
        end
        PH_NUMBER: begin
          if (b == CH_QUOTE) begin
            parse_ph  = PH_SKIP_TO_NAME;
            skip_left = 2'd2;
          end else begin
            emit = take_field_char(KIND_NUMBER, b, NUMBER_MAX_LEN, item);
          end
        end
        PH_SKIP_TO_NAME: if (skip_finished()) parse_ph = PH_NAME;
        PH_NAME: if (b == CH_QUOTE) begin
          parse_ph  = PH_SKIP_TO_DATE;
          skip_left = 2'd2;
        end
        PH_SKIP_TO_DATE: if (skip_finished()) begin
          parse_ph  = PH_DATE;
          field_len = '0;
        end
        PH_DATE: begin
          if (b == CH_QUOTE) begin
            parse_ph  = PH_SKIP_TO_MSG;
            skip_left = 2'd1;
          end else begin
            emit = take_field_char(KIND_DATETIME, b, DATETIME_MAX_LEN, item);
          end
        end
        PH_SKIP_TO_MSG: if (skip_finished()) begin
          parse_ph  = PH_MESSAGE;
          field_len = '0;
        end
        PH_MESSAGE: begin
          if (b == CH_LF) begin
            item     = make_item(KIND_REC_END, 8'h00, rec_count[3:0] - 4'd1, 1'b1);
            emit     = 1'b1;
            parse_ph = PH_SEARCH;
            tag_pos  = '0;
          end else begin
            emit = take_field_char(KIND_MESSAGE, b, MESSAGE_MAX_LEN, item);
          end
        end
        default: begin
          parse_ph = PH_SEARCH;
          tag_pos  = '0;
        end
      endcase
    end
    // end of response: an open record whose header went out is closed as cut,
    // overriding any character result of this byte
    if (last) begin
      if (parse_ph >= PH_SKIP_TO_NUMBER && parse_ph <= PH_MESSAGE) begin
        item = make_item(KIND_REC_END, 8'h00, rec_count[3:0] - 4'd1, 1'b0);
        emit = 1'b1;
      end
      clear_parser();
    end
    return emit;
  endfunction

  // ---------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------
  // one input transfer, with an optional idle burst in front of it
  task automatic push_byte(input logic [7:0] b, input logic last);
    out_item_t item;
    if (sender_gap_pct != 0 && $urandom_range(0, 99) < sender_gap_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= {b, last};
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    if (parse_text_byte(b, last, item)) predicted_items.push_back(item);
    byte_count++;
  endtask

  // hold the sender until every predicted result has come out
  task automatic wait_for_drain();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (predicted_items.size() != 0);
  endtask

  // sends the first len bytes of the built text, the last one flagged
  task automatic send_text(input int len);
    if (text_q.size() == 0) text_q.push_back(8'($urandom_range(0, 255)));
    if (len < 1 || len > text_q.size()) len = text_q.size();
    for (int i = 0; i < len; i++) push_byte(text_q[i], i == len - 1);
    text_q.delete();
  endtask

  // ---------------------------------------------------------------------
  // response text generation
  // ---------------------------------------------------------------------
  function automatic logic [7:0] rand_text_char(input logic [7:0] stop);
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (c == stop || c == CH_CR) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  task automatic put_char(input logic [7:0] b);
    if (cr_noise_pct != 0 && $urandom_range(0, 99) < cr_noise_pct) text_q.push_back(CH_CR);
    text_q.push_back(b);
  endtask

  task automatic put_string(input string s);
    for (int i = 0; i < s.len(); i++) put_char(s[i]);
  endtask

  function automatic string status_word(input int sel);
    case (sel)
      0:       return "REC UNREAD";
      1:       return "REC READ";
      2:       return "STO UNSENT";
      3:       return "STO SENT";
      4:       return "ALL";
      5:       return "";
      6:       return "REC";
      default: return "STORED";
    endcase
  endfunction

  // field length: mostly short, now and then around the limit
  function automatic int pick_len(input int typical, input int limit);
    if ($urandom_range(0, 11) == 0) return $urandom_range(limit - 2, limit + 4);
    return $urandom_range(0, typical);
  endfunction

  // one well-formed record; status selector 8 gives a random word
  task automatic add_record(input int slot_digits, input int status_sel, input int num_len,
                            input int name_len, input int date_len, input int msg_len);
    string      letters;
    logic [7:0] c;
    letters = "RSAU";
    if ($urandom_range(0, 3) != 0) begin
      put_string("+CMGL: ");
    end else begin
      put_string("+CMGL");
      put_char(rand_text_char(CH_CR));
      put_char(rand_text_char(CH_CR));
    end
    repeat (slot_digits) put_char(CH_ZERO + 8'($urandom_range(0, 9)));
    // slot ends on any non-digit
    if ($urandom_range(0, 3) != 0) begin
      put_string(",");
    end else begin
      c = rand_text_char(CH_CR);
      while (c >= CH_ZERO && c <= CH_NINE) c = rand_text_char(CH_CR);
      put_char(c);
    end
    put_string("\"");
    if (status_sel < 8) begin
      put_string(status_word(status_sel));
    end else begin
      repeat ($urandom_range(0, 8)) begin
        if ($urandom_range(0, 1) != 0) put_char(letters[$urandom_range(0, 3)]);
        else put_char(rand_text_char(CH_QUOTE));
      end
    end
    put_string("\",\"");
    repeat (num_len) put_char(rand_text_char(CH_QUOTE));
    put_string("\",\"");
    repeat (name_len) put_char(rand_text_char(CH_QUOTE));
    put_string("\",\"");
    repeat (date_len) put_char(rand_text_char(CH_QUOTE));
    put_string("\"\r\n");
    // a tag inside the message is only text
    if ($urandom_range(0, 9) == 0) put_string("+CMGL");
    repeat (msg_len) put_char(rand_text_char(CH_LF));
    put_string("\r\n");
  endtask

  task automatic add_random_record();
    add_record($urandom_range(0, 6), $urandom_range(0, 8),
               pick_len(12, NUMBER_MAX_LEN), pick_len(6, 8),
               pick_len(20, DATETIME_MAX_LEN), pick_len(30, MESSAGE_MAX_LEN));
  endtask

  // bytes outside records, including tag fragments that must not match
  task automatic put_noise();
    case ($urandom_range(0, 3))
      0:       put_char(8'($urandom_range(0, 255)));
      1:       put_string("+");
      2:       put_string("+CM");
      default: put_string("+CMG+C");
    endcase
  endtask

  task automatic build_response(input int n_records);
    text_q.delete();
    repeat ($urandom_range(0, 3)) put_noise();
    repeat (n_records) begin
      add_random_record();
      if ($urandom_range(0, 3) == 0) put_noise();
    end
    put_string("\r\nOK\r\n");
  endtask

  function automatic int pick_idle_pct();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 15;
      default: return 40;
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------
  // hand-written responses: tag restart, slot saturation, extreme field
  // bytes, newline together with the last byte, cuts after and before the
  // header, and a carriage return as the last byte
  task automatic test_directed_records();
    sender_gap_pct = 20;
    sink_stall_pct = 20;
    cr_noise_pct   = 0;
    put_string("+C+CMGL: 99999,\"REC UNREAD\",\"");
    text_q.push_back(8'h00);
    text_q.push_back(8'hFF);
    put_string("\",\"\",\"\"\r\nA\n");
    send_text(text_q.size());
    put_string("+CMGL: 7,\"ALL\",\"12");
    send_text(text_q.size());
    put_string("+CMGL: 3,\"STO");
    send_text(text_q.size());
    put_string("+CMGL: 1,\"S\"\r");
    send_text(text_q.size());
  endtask

  // every status word and the malformed ones, in one response
  task automatic test_status_classes();
    cr_noise_pct = 5;
    text_q.delete();
    for (int sel = 0; sel <= 8; sel++) add_record($urandom_range(1, 6), sel, 1, 0, 1, 1);
    put_string("\r\nOK\r\n");
    send_text(text_q.size());
  endtask

  // fields just over their limits, then number and date fields exactly at them
  task automatic test_field_limits();
    text_q.delete();
    add_record(2, 1, NUMBER_MAX_LEN + 1, 0, DATETIME_MAX_LEN + 1, MESSAGE_MAX_LEN + 1);
    add_record(1, 4, NUMBER_MAX_LEN, 0, DATETIME_MAX_LEN, 1);
    put_string("\r\nOK\r\n");
    send_text(text_q.size());
  endtask

  // records past the limit are ignored; the next response counts afresh
  task automatic test_record_limit();
    cr_noise_pct = 0;
    text_q.delete();
    repeat (MAX_RECORDS + 1) add_record(1, 4, 0, 0, 0, 0);
    put_string("OK\r\n");
    send_text(text_q.size());
    add_record(2, 0, 1, 1, 1, 1);
    send_text(text_q.size());
  endtask

  // mostly well-formed responses with random content; some get a byte
  // overwritten, some are cut short by the last byte
  task automatic test_random_responses(input int n_bytes);
    int stop_at;
    int len;
    bit first;
    stop_at      = byte_count + n_bytes;
    first        = 1'b1;
    cr_noise_pct = 5;
    while (byte_count < stop_at) begin
      sender_gap_pct = pick_idle_pct();
      sink_stall_pct = pick_idle_pct();
      build_response($urandom_range(1, 4));
      if ($urandom_range(0, 4) == 0)
        text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(0, 255));
      len = text_q.size();
      if ($urandom_range(0, 3) == 0) len = $urandom_range(1, len);
      send_text(len);
      if (first || $urandom_range(0, 5) == 0) wait_for_drain();
      first = 1'b0;
    end
  endtask

  // back-to-back transfers on both sides to finish
  task automatic test_steady_stream();
    sender_gap_pct = 0;
    sink_stall_pct = 0;
    build_response(1);
    send_text(text_q.size());
  endtask

  // ---------------------------------------------------------------------
  // receiver side: random stall bursts on ready
  // ---------------------------------------------------------------------
  int stall_left = 0;

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else if (sink_stall_pct != 0 && $urandom_range(0, 99) < sink_stall_pct) begin
      stall_left = $urandom_range(0, 4);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------
  // result checking against the oldest prediction
  // ---------------------------------------------------------------------
  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    out_item_t want;
    out_item_t got;
    if (out_if.valid && out_if.ready) begin
      got = out_if.payload;
      if (predicted_items.size() == 0) begin
        $error("result transfer with no prediction waiting, item_kind %0d", got.item_kind);
        fail_count++;
      end else begin
        want = predicted_items.pop_front();
        check_field("item_kind", want.item_kind, got.item_kind);
        check_field("char_value", want.char_value, got.char_value);
        check_field("slot_number", want.slot_number, got.slot_number);
        check_field("status_code", want.status_code, got.status_code);
        check_field("record_index", want.record_index, got.record_index);
        check_field("record_complete", want.record_complete, got.record_complete);
      end
    end
  end

  // ---------------------------------------------------------------------
  // watchdog: too long without any transfer means the block is hung
  // ---------------------------------------------------------------------
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("sms_list_response_parser_top test failed");
    $finish;
  end

  // ---------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------
  initial begin
    rst_ni        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.payload = '0;
    out_if.ready  = 1'b0;
    clear_parser();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_records();
    test_status_classes();
    test_field_limits();
    test_record_limit();
    test_random_responses(RANDOM_BYTES);
    test_steady_stream();

    // let the pipeline empty, then a short settle time
    in_if.valid <= 1'b0;
    while (predicted_items.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("sms_list_response_parser_top test passed");
    end else begin
      $display("sms_list_response_parser_top test failed");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/smslp_pkg.sv
hw/rtl/smslp_stream_if.sv
hw/rtl/smslp_in_stage.sv
hw/rtl/smslp_parser.sv
hw/rtl/smslp_out_stage.sv
hw/rtl/sms_list_response_parser_top.sv
bench/testbench.sv
